>>> rtl/wtbms_pkg.sv
package wtbms_pkg;

    // Default table depths for the top-level parameters.
    localparam int unsigned DEF_TAG_SLOTS   = 1024;
    localparam int unsigned DEF_ASSET_SLOTS = 1024;
    localparam int unsigned DEF_TYPE_SLOTS  = 64;
    localparam int unsigned DEF_TAG_KINDS   = 16;

    localparam int unsigned SPAN_W  = 11;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned DIST_W  = 35;
    localparam int unsigned DHI_W   = DIST_W - 16;
    localparam int unsigned PROD_W  = VALUE_W + DHI_W;

    // Command codes.
    localparam logic [2:0] CMD_LOAD_TAG   = 3'd0;
    localparam logic [2:0] CMD_LOAD_ASSET = 3'd1;
    localparam logic [2:0] CMD_LOAD_TYPE  = 3'd2;
    localparam logic [2:0] CMD_SET_KIND   = 3'd3;
    localparam logic [2:0] CMD_QUERY      = 3'd4;

    typedef struct packed {
        logic [2:0]               command;
        logic [9:0]               slot;
        logic [KIND_W-1:0]        tag_kind;
        logic signed [VALUE_W-1:0] value;
        logic [VALUE_W-1:0]       weight;
        logic [VALUE_W-1:0]       wrap_period;
        logic [SPAN_W-1:0]        span_first;
        logic [SPAN_W-1:0]        span_end;
        logic [5:0]               query_type;
    } wtbms_in_t;

    typedef struct packed {
        logic [9:0]       best_asset;
        logic [SUM_W-1:0] best_distance;
        logic             found;
    } wtbms_out_t;

    // One entry of the per-kind table.
    typedef struct packed {
        logic signed [VALUE_W-1:0] match;
        logic [VALUE_W-1:0]        weight;
        logic [VALUE_W-1:0]        period;
    } kind_entry_t;

    // Step strobes from the sequencer to the term unit.
    typedef struct packed {
        logic load;
        logic min_dist;
        logic mul_hi;
        logic mul_lo;
        logic fin;
    } term_ctrl_t;

    // Clips a span end to the depth of the table it indexes.
    function automatic logic [SPAN_W-1:0] clip_end(input logic [SPAN_W-1:0] span_end,
                                                   input int unsigned depth);
        if (32'(span_end) > depth)
            return SPAN_W'(depth);
        return span_end;
    endfunction

endpackage

>>> rtl/wtbms_ram.sv
module wtbms_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 22
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/wtbms_kind_table.sv
module wtbms_kind_table #(
    parameter int unsigned TAG_KINDS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [$clog2(TAG_KINDS)-1:0] wr_addr,
    input  wtbms_pkg::kind_entry_t       wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(TAG_KINDS)-1:0] rd_addr,
    output wtbms_pkg::kind_entry_t       rd_data
);
    import wtbms_pkg::*;

    kind_entry_t          mem [TAG_KINDS];
    logic [TAG_KINDS-1:0] valid_reg;
    kind_entry_t          rd_data_reg;
    logic                 rd_valid_reg;

    // Entries never written read as match 0, weight 0, period all ones.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        if (rd_valid_reg)
            rd_data = rd_data_reg;
        else
        begin
            rd_data.match  = '0;
            rd_data.weight = '0;
            rd_data.period = '1;
        end
    end

endmodule

>>> rtl/wtbms_term_unit.sv
module wtbms_term_unit (
    input  logic                                      clk,
    input  wtbms_pkg::term_ctrl_t                     ctrl,
    input  wtbms_pkg::kind_entry_t                    kind,
    input  logic                                      kind_ok,
    input  logic signed [wtbms_pkg::VALUE_W-1:0]      tag_value,
    output logic [wtbms_pkg::SUM_W-1:0]               term
);
    import wtbms_pkg::*;

    logic signed [DIST_W-1:0]  diff0_reg;
    logic signed [DIST_W-1:0]  alt_reg;
    logic signed [DIST_W-1:0]  b_reg;
    logic [VALUE_W-1:0]        w_reg;
    logic [DIST_W-1:0]         d_reg;
    logic [PROD_W-1:0]         mul_reg;
    logic [PROD_W-1:0]         hi_reg;
    logic [SUM_W-1:0]          term_reg;

    logic signed [DIST_W-1:0]  a_ext;
    logic signed [DIST_W-1:0]  b_ext;
    logic signed [DIST_W-1:0]  p_ext;
    logic signed [DIST_W-1:0]  diff1;
    logic [DIST_W-1:0]         abs0;
    logic [DIST_W-1:0]         abs1;
    logic [DHI_W-1:0]          mul_b;
    logic [PROD_W-1:0]         mul_out;
    logic [PROD_W:0]           total;

    assign a_ext = DIST_W'(kind.match);
    assign b_ext = DIST_W'(tag_value);
    assign p_ext = $signed({3'b000, kind.period});

    assign diff1 = alt_reg - b_reg;
    assign abs0  = diff0_reg[DIST_W-1] ? DIST_W'(-diff0_reg) : DIST_W'(diff0_reg);
    assign abs1  = diff1[DIST_W-1] ? DIST_W'(-diff1) : DIST_W'(diff1);

    // The one multiplier takes the high distance bits first, then the low 16.
    assign mul_b   = ctrl.mul_lo ? DHI_W'(d_reg[15:0]) : d_reg[DIST_W-1:16];
    assign mul_out = PROD_W'(w_reg) * PROD_W'(mul_b);

    assign total = {1'b0, hi_reg} + (PROD_W + 1)'(mul_reg[PROD_W-1:16]);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            diff0_reg <= a_ext - b_ext;
            alt_reg   <= kind.match[VALUE_W-1] ? (a_ext + p_ext) : (a_ext - p_ext);
            b_reg     <= b_ext;
            w_reg     <= kind_ok ? kind.weight : '0;
        end
        if (ctrl.min_dist)
            d_reg <= (abs0 < abs1) ? abs0 : abs1;
        if (ctrl.mul_hi)
            mul_reg <= mul_out;
        if (ctrl.mul_lo)
        begin
            hi_reg  <= mul_reg;
            mul_reg <= mul_out;
        end
        if (ctrl.fin)
            term_reg <= (|total[PROD_W:SUM_W]) ? '1 : total[SUM_W-1:0];
    end

    assign term = term_reg;

endmodule

>>> rtl/weighted_tag_best_match_search_top.sv
// Channel | Signals                          | Direction | Carries
// cmd     | cmd_valid, cmd_ready, cmd        | in        | load commands and queries
// res     | res_valid, res_ready, res        | out       | one result per query
//
// A load command is a single-cycle transfer that writes one table entry if its slot lies inside the table.
// A query walks the type's assets and, for each asset, its tags:
// each tag goes through tag read, kind read and the shared distance/multiplier
// unit in eight steps, and each asset costs a span read and a compare.
// Reset (rst_n, asynchronous) clears the sequencer, the result and the kind valid bits.
// A finished query waits for the output register to free; cmd_ready stays low meanwhile.
module weighted_tag_best_match_search_top #(
    parameter int unsigned TAG_SLOTS   = wtbms_pkg::DEF_TAG_SLOTS,
    parameter int unsigned ASSET_SLOTS = wtbms_pkg::DEF_ASSET_SLOTS,
    parameter int unsigned TYPE_SLOTS  = wtbms_pkg::DEF_TYPE_SLOTS,
    parameter int unsigned TAG_KINDS   = wtbms_pkg::DEF_TAG_KINDS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  wtbms_pkg::wtbms_in_t  cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output wtbms_pkg::wtbms_out_t res
);
    import wtbms_pkg::*;

    localparam int unsigned TAG_AW   = $clog2(TAG_SLOTS);
    localparam int unsigned ASSET_AW = $clog2(ASSET_SLOTS);
    localparam int unsigned TYPE_AW  = $clog2(TYPE_SLOTS);
    localparam int unsigned KIND_AW  = $clog2(TAG_KINDS);
    localparam int unsigned SPAN2_W  = 2 * SPAN_W;
    localparam int unsigned TAG_DW   = KIND_W + VALUE_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TYPE_WAIT,
        ST_ASSET_RD,
        ST_ASSET_WAIT,
        ST_TAG_RD,
        ST_TAG_WAIT,
        ST_KIND_WAIT,
        ST_DIST,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_FIN,
        ST_ACC,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [SPAN_W-1:0] a_cnt_reg;
    logic [SPAN_W-1:0] a_end_reg;
    logic [SPAN_W-1:0] t_cnt_reg;
    logic [SPAN_W-1:0] t_end_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  best_reg;
    logic [9:0]        best_idx_reg;
    logic              found_reg;
    logic              kind_ok_reg;
    logic              res_valid_reg;
    wtbms_out_t        res_reg;

    logic              accept;
    logic              tag_wr, asset_wr, type_wr, kind_wr;
    logic              tag_rd, asset_rd, type_rd, kind_rd;
    logic [TAG_DW-1:0] tag_data;
    logic [SPAN2_W-1:0] asset_data;
    logic [SPAN2_W-1:0] type_data;
    kind_entry_t       kind_wr_data;
    kind_entry_t       kind_data;
    term_ctrl_t        ctrl;
    logic [SUM_W-1:0]  term;

    logic [SPAN_W-1:0] type_first, type_end_clip;
    logic [SPAN_W-1:0] asset_first, asset_end_clip;
    logic [KIND_W-1:0] tag_kind_rd;
    logic [SPAN_W:0]   t_cnt_inc, a_cnt_inc;
    logic [SUM_W:0]    acc_sum;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    assign type_first     = type_data[SPAN2_W-1:SPAN_W];
    assign type_end_clip  = clip_end(type_data[SPAN_W-1:0], ASSET_SLOTS);
    assign asset_first    = asset_data[SPAN2_W-1:SPAN_W];
    assign asset_end_clip = clip_end(asset_data[SPAN_W-1:0], TAG_SLOTS);
    assign tag_kind_rd    = tag_data[TAG_DW-1:VALUE_W];

    assign t_cnt_inc = {1'b0, t_cnt_reg} + 1'b1;
    assign a_cnt_inc = {1'b0, a_cnt_reg} + 1'b1;
    assign acc_sum   = {1'b0, sum_reg} + {1'b0, term};

    assign kind_wr_data.match  = cmd.value;
    assign kind_wr_data.weight = cmd.weight;
    assign kind_wr_data.period = cmd.wrap_period;

    // Table writes happen only on load transfers; reads follow the sequencer.
    always_comb
    begin
        tag_wr   = 1'b0;
        asset_wr = 1'b0;
        type_wr  = 1'b0;
        kind_wr  = 1'b0;
        type_rd  = 1'b0;
        asset_rd = 1'b0;
        tag_rd   = 1'b0;
        kind_rd  = 1'b0;
        ctrl     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.command)
                        CMD_LOAD_TAG:   tag_wr   = (32'(cmd.slot) < TAG_SLOTS);
                        CMD_LOAD_ASSET: asset_wr = (32'(cmd.slot) < ASSET_SLOTS);
                        CMD_LOAD_TYPE:  type_wr  = (32'(cmd.slot) < TYPE_SLOTS);
                        CMD_SET_KIND:   kind_wr  = (32'(cmd.slot) < TAG_KINDS);
                        CMD_QUERY:      type_rd  = (32'(cmd.query_type) < TYPE_SLOTS);
                        default:        ;
                    endcase
                end
            end
            ST_ASSET_RD:  asset_rd      = 1'b1;
            ST_TAG_RD:    tag_rd        = 1'b1;
            ST_TAG_WAIT:  kind_rd       = 1'b1;
            ST_KIND_WAIT: ctrl.load     = 1'b1;
            ST_DIST:      ctrl.min_dist = 1'b1;
            ST_MUL_HI:    ctrl.mul_hi   = 1'b1;
            ST_MUL_LO:    ctrl.mul_lo   = 1'b1;
            ST_FIN:       ctrl.fin      = 1'b1;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            a_cnt_reg     <= '0;
            a_end_reg     <= '0;
            t_cnt_reg     <= '0;
            t_end_reg     <= '0;
            sum_reg       <= '0;
            best_reg      <= '0;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
            kind_ok_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            // In ST_DONE the output register is refilled in the same cycle instead.
            if (res_valid_reg && res_ready && state_reg != ST_DONE)
                res_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && cmd.command == CMD_QUERY)
                    begin
                        best_reg     <= '0;
                        best_idx_reg <= '0;
                        found_reg    <= 1'b0;
                        // A type outside the table is an empty range.
                        if (32'(cmd.query_type) < TYPE_SLOTS)
                            state_reg <= ST_TYPE_WAIT;
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_TYPE_WAIT:
                begin
                    a_cnt_reg <= type_first;
                    a_end_reg <= type_end_clip;
                    if (type_first < type_end_clip)
                        state_reg <= ST_ASSET_RD;
                    else
                        state_reg <= ST_DONE;
                end
                ST_ASSET_RD:
                    state_reg <= ST_ASSET_WAIT;
                ST_ASSET_WAIT:
                begin
                    t_cnt_reg <= asset_first;
                    t_end_reg <= asset_end_clip;
                    sum_reg   <= '0;
                    if (asset_first < asset_end_clip)
                        state_reg <= ST_TAG_RD;
                    else
                        state_reg <= ST_CMP;
                end
                ST_TAG_RD:
                    state_reg <= ST_TAG_WAIT;
                ST_TAG_WAIT:
                begin
                    kind_ok_reg <= (32'(tag_kind_rd) < TAG_KINDS);
                    state_reg   <= ST_KIND_WAIT;
                end
                ST_KIND_WAIT:
                    state_reg <= ST_DIST;
                ST_DIST:
                    state_reg <= ST_MUL_HI;
                ST_MUL_HI:
                    state_reg <= ST_MUL_LO;
                ST_MUL_LO:
                    state_reg <= ST_FIN;
                ST_FIN:
                    state_reg <= ST_ACC;
                ST_ACC:
                begin
                    sum_reg   <= acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
                    t_cnt_reg <= t_cnt_inc[SPAN_W-1:0];
                    if (t_cnt_inc < {1'b0, t_end_reg})
                        state_reg <= ST_TAG_RD;
                    else
                        state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    // The first asset always leads; later ones must be strictly better.
                    if (!found_reg || sum_reg < best_reg)
                    begin
                        best_reg     <= sum_reg;
                        best_idx_reg <= a_cnt_reg[9:0];
                    end
                    found_reg <= 1'b1;
                    a_cnt_reg <= a_cnt_inc[SPAN_W-1:0];
                    if (a_cnt_inc < {1'b0, a_end_reg})
                        state_reg <= ST_ASSET_RD;
                    else
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg         <= 1'b1;
                        res_reg.best_asset    <= best_idx_reg;
                        res_reg.best_distance <= best_reg;
                        res_reg.found         <= found_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    wtbms_ram #(
        .DEPTH (TAG_SLOTS),
        .WIDTH (TAG_DW)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr),
        .wr_addr (TAG_AW'(cmd.slot)),
        .wr_data ({cmd.tag_kind, cmd.value}),
        .rd_en   (tag_rd),
        .rd_addr (TAG_AW'(t_cnt_reg)),
        .rd_data (tag_data)
    );

    wtbms_ram #(
        .DEPTH (ASSET_SLOTS),
        .WIDTH (SPAN2_W)
    ) u_asset_ram (
        .clk     (clk),
        .wr_en   (asset_wr),
        .wr_addr (ASSET_AW'(cmd.slot)),
        .wr_data ({cmd.span_first, cmd.span_end}),
        .rd_en   (asset_rd),
        .rd_addr (ASSET_AW'(a_cnt_reg)),
        .rd_data (asset_data)
    );

    wtbms_ram #(
        .DEPTH (TYPE_SLOTS),
        .WIDTH (SPAN2_W)
    ) u_type_ram (
        .clk     (clk),
        .wr_en   (type_wr),
        .wr_addr (TYPE_AW'(cmd.slot)),
        .wr_data ({cmd.span_first, cmd.span_end}),
        .rd_en   (type_rd),
        .rd_addr (TYPE_AW'(cmd.query_type)),
        .rd_data (type_data)
    );

    wtbms_kind_table #(
        .TAG_KINDS (TAG_KINDS)
    ) u_kind_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (kind_wr),
        .wr_addr (KIND_AW'(cmd.slot)),
        .wr_data (kind_wr_data),
        .rd_en   (kind_rd),
        .rd_addr (KIND_AW'(tag_kind_rd)),
        .rd_data (kind_data)
    );

    wtbms_term_unit u_term_unit (
        .clk       (clk),
        .ctrl      (ctrl),
        .kind      (kind_data),
        .kind_ok   (kind_ok_reg),
        .tag_value ($signed(tag_data[VALUE_W-1:0])),
        .term      (term)
    );

endmodule
